>>> rtl/core/qte_pkg.sv
package qte_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W = $clog2(ATAN_ENTRIES);
   localparam int IN_W = 16;
   localparam int PROD_W = 2 * IN_W;
   localparam int OP_W = 35;
   localparam int CORDIC_W = 38;
   localparam int ACC_W = 32;
   localparam int ANG_W = 16;
   localparam int MAG_W = 28;
   localparam int SQ_W = 2 * MAG_W;
   localparam int ROOT_W = MAG_W + 1;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int RAD_W = 58;
   localparam int CORDIC_LAT = CORDIC_STEPS + 2;
   localparam int PIPE_DEPTH = SQRT_STEPS + CORDIC_LAT + 3;

   typedef logic signed [IN_W-1:0]     quat_type;
   typedef logic signed [PROD_W-1:0]   product_type;
   typedef logic signed [OP_W-1:0]     operand_type;
   typedef logic signed [CORDIC_W-1:0] cordic_type;
   typedef logic [ACC_W-1:0]           acc_type;
   typedef logic signed [ANG_W-1:0]    angle_type;
   typedef logic [RAD_W-1:0]           radicand_type;
   typedef logic [ROOT_W-1:0]          root_type;

   typedef struct packed {
      operand_type sr;
      operand_type cr;
      operand_type sy;
      operand_type cy;
      operand_type sp;
   } operands_type;

   localparam operand_type ONE_Q28 = operand_type'(268435456);
   localparam angle_type HALF_PI_OUT = angle_type'(16384);
   localparam acc_type ACC_PI = 32'h8000_0000;
   localparam acc_type ACC_ROUND = 32'h0000_8000;

   function automatic acc_type atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      acc_type val;
      case (idx)
         5'd0: val = 32'd536870912;
         5'd1: val = 32'd316933406;
         5'd2: val = 32'd167458907;
         5'd3: val = 32'd85004756;
         5'd4: val = 32'd42667331;
         5'd5: val = 32'd21354465;
         5'd6: val = 32'd10679838;
         5'd7: val = 32'd5340245;
         5'd8: val = 32'd2670163;
         5'd9: val = 32'd1335086;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         5'd20: val = 32'd652;
         5'd21: val = 32'd326;
         5'd22: val = 32'd163;
         5'd23: val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> rtl/core/qte_if.sv
interface qte_req_if;
   logic valid;
   logic ready;
   qte_pkg::quat_type quat_w;
   qte_pkg::quat_type quat_x;
   qte_pkg::quat_type quat_y;
   qte_pkg::quat_type quat_z;

   modport source(output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
   modport sink(input valid, input quat_w, input quat_x, input quat_y,
                input quat_z, output ready);
endinterface

interface qte_rsp_if;
   logic valid;
   logic ready;
   qte_pkg::angle_type roll_angle;
   qte_pkg::angle_type pitch_angle;
   qte_pkg::angle_type yaw_angle;
   logic pitch_saturated;

   modport source(output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, output pitch_saturated, input ready);
   modport sink(input valid, input roll_angle, input pitch_angle,
                input yaw_angle, input pitch_saturated, output ready);
endinterface

>>> rtl/core/qte_sqrt.sv
module qte_sqrt (
   input  logic                 clock,
   input  logic                 enable,
   input  qte_pkg::radicand_type radicand,
   output qte_pkg::root_type     root
);
   import qte_pkg::*;

   radicand_type rem_ff [SQRT_STEPS];
   radicand_type res_ff [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam radicand_type BIT_VAL = radicand_type'(1) << (2 * (SQRT_STEPS - 1 - k));
      radicand_type rem_in;
      radicand_type res_in;
      radicand_type trial;

      if (k == 0) begin : g_first
         assign rem_in = radicand;
         assign res_in = '0;
      end else begin : g_next
         assign rem_in = rem_ff[k-1];
         assign res_in = res_ff[k-1];
      end

      assign trial = res_in + BIT_VAL;

      always_ff @(posedge clock) begin
         if (enable) begin
            if (rem_in >= trial) begin
               rem_ff[k] <= rem_in - trial;
               res_ff[k] <= (res_in >> 1) + BIT_VAL;
            end else begin
               rem_ff[k] <= rem_in;
               res_ff[k] <= res_in >> 1;
            end
         end
      end
   end

   assign root = res_ff[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

>>> rtl/core/qte_cordic.sv
module qte_cordic (
   input  logic               clock,
   input  logic               enable,
   input  qte_pkg::cordic_type vec_y,
   input  qte_pkg::cordic_type vec_x,
   output qte_pkg::angle_type  angle
);
   import qte_pkg::*;

   cordic_type x_ff [CORDIC_STEPS+1];
   cordic_type y_ff [CORDIC_STEPS+1];
   acc_type acc_ff [CORDIC_STEPS+1];
   logic zero_ff [CORDIC_STEPS+1];
   angle_type angle_ff;
   acc_type rounded;

   always_ff @(posedge clock) begin
      if (enable) begin
         zero_ff[0] <= (vec_x == '0) && (vec_y == '0);
         if (vec_x < 0) begin
            x_ff[0] <= -vec_x;
            y_ff[0] <= -vec_y;
            acc_ff[0] <= ACC_PI;
         end else begin
            x_ff[0] <= vec_x;
            y_ff[0] <= vec_y;
            acc_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (enable) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               acc_ff[i+1] <= acc_ff[i] + atan_entry(ATAN_IDX_W'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               acc_ff[i+1] <= acc_ff[i] - atan_entry(ATAN_IDX_W'(i));
            end
         end
      end
   end

   assign rounded = acc_ff[CORDIC_STEPS] + ACC_ROUND;

   always_ff @(posedge clock) begin
      if (enable) begin
         angle_ff <= zero_ff[CORDIC_STEPS] ? '0 : angle_type'(rounded[ACC_W-1:ACC_W-ANG_W]);
      end
   end

   assign angle = angle_ff;

endmodule

>>> rtl/core/quaternion_to_euler_angles.sv
// Converts a Q1.14 quaternion into roll, pitch and yaw binary angles (32768 is pi). One request
// is taken every cycle while the response is not stalled; the latency is set by the 29-stage
// square root feeding the pitch arcsine and the CORDIC stages behind it. A stalled response
// freezes the whole pipeline.
module quaternion_to_euler_angles (
   input logic       clock,
   input logic       reset,
   qte_req_if.sink   req_chan,
   qte_rsp_if.source rsp_chan
);
   import qte_pkg::*;

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:1] sat_ff;
   logic [PIPE_DEPTH-1:1] neg_ff;
   logic advance;

   product_type wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, xz_ff;
   operand_type sr_in, cr_in, sy_in, cy_in, sp_in;
   operand_type sr_ff, cr_ff, sy_ff, cy_ff, sp_ff;
   logic sat_in;
   operand_type abs_sp;
   logic [MAG_W-1:0] mag;
   logic [SQ_W-1:0] mag_sq;
   radicand_type rest_in;
   radicand_type rest_ff;
   operands_type ops_ff [SQRT_STEPS+1];
   root_type root;
   operands_type ops_out;
   angle_type roll, pitch, yaw;

   assign advance = !valid_ff[PIPE_DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wx_ff <= req_chan.quat_w * req_chan.quat_x;
         yz_ff <= req_chan.quat_y * req_chan.quat_z;
         xx_ff <= req_chan.quat_x * req_chan.quat_x;
         yy_ff <= req_chan.quat_y * req_chan.quat_y;
         wz_ff <= req_chan.quat_w * req_chan.quat_z;
         xy_ff <= req_chan.quat_x * req_chan.quat_y;
         zz_ff <= req_chan.quat_z * req_chan.quat_z;
         wy_ff <= req_chan.quat_w * req_chan.quat_y;
         xz_ff <= req_chan.quat_x * req_chan.quat_z;
      end
   end

   assign sr_in = (operand_type'(wx_ff) + operand_type'(yz_ff)) <<< 1;
   assign cr_in = ONE_Q28 - ((operand_type'(xx_ff) + operand_type'(yy_ff)) <<< 1);
   assign sy_in = (operand_type'(wz_ff) + operand_type'(xy_ff)) <<< 1;
   assign cy_in = ONE_Q28 - ((operand_type'(yy_ff) + operand_type'(zz_ff)) <<< 1);
   assign sp_in = (operand_type'(wy_ff) - operand_type'(xz_ff)) <<< 1;
   assign sat_in = (sp_in >= ONE_Q28) || (sp_in <= -ONE_Q28);

   always_ff @(posedge clock) begin
      if (advance) begin
         sr_ff <= sr_in;
         cr_ff <= cr_in;
         sy_ff <= sy_in;
         cy_ff <= cy_in;
         sp_ff <= sp_in;
         sat_ff <= {sat_ff[PIPE_DEPTH-2:1], sat_in};
         neg_ff <= {neg_ff[PIPE_DEPTH-2:1], sp_in[OP_W-1]};
      end
   end

   // Only the unsaturated case uses the root, where the magnitude is below one.
   assign abs_sp = sp_ff[OP_W-1] ? -sp_ff : sp_ff;
   assign mag = abs_sp[MAG_W-1:0];
   assign mag_sq = mag * mag;
   assign rest_in = (radicand_type'(1) << SQ_W) - radicand_type'(mag_sq);

   always_ff @(posedge clock) begin
      if (advance) begin
         rest_ff <= rest_in;
         ops_ff[0] <= '{sr: sr_ff, cr: cr_ff, sy: sy_ff, cy: cy_ff, sp: sp_ff};
         for (int k = 1; k <= SQRT_STEPS; k++) begin
            ops_ff[k] <= ops_ff[k-1];
         end
      end
   end

   qte_sqrt u_sqrt (
      .clock    (clock),
      .enable   (advance),
      .radicand (rest_ff),
      .root     (root)
   );

   assign ops_out = ops_ff[SQRT_STEPS];

   qte_cordic u_roll (
      .clock  (clock),
      .enable (advance),
      .vec_y  (cordic_type'(ops_out.sr)),
      .vec_x  (cordic_type'(ops_out.cr)),
      .angle  (roll)
   );

   qte_cordic u_pitch (
      .clock  (clock),
      .enable (advance),
      .vec_y  (cordic_type'(ops_out.sp)),
      .vec_x  (cordic_type'(root)),
      .angle  (pitch)
   );

   qte_cordic u_yaw (
      .clock  (clock),
      .enable (advance),
      .vec_y  (cordic_type'(ops_out.sy)),
      .vec_x  (cordic_type'(ops_out.cy)),
      .angle  (yaw)
   );

   assign rsp_chan.valid = valid_ff[PIPE_DEPTH-1];
   assign rsp_chan.roll_angle = roll;
   assign rsp_chan.yaw_angle = yaw;
   assign rsp_chan.pitch_saturated = sat_ff[PIPE_DEPTH-1];
   assign rsp_chan.pitch_angle = sat_ff[PIPE_DEPTH-1] ?
                                 (neg_ff[PIPE_DEPTH-1] ? -HALF_PI_OUT : HALF_PI_OUT) : pitch;

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock) reset |=> valid_ff == '0)
      else $error("pipeline not empty after reset");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> $stable(valid_ff))
      else $error("pipeline moved while the response was stalled");

   a_sat_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.pitch_saturated |->
      (rsp_chan.pitch_angle == HALF_PI_OUT || rsp_chan.pitch_angle == -HALF_PI_OUT))
      else $error("saturated pitch is not a right angle");
`endif

endmodule
